FILE: hdl/ske_pkg.sv
// Shared byte codes for the sort key encoder.
package ske_pkg;

  localparam logic [7:0] K_KEY_START   = 8'h30;
  localparam logic [7:0] K_EMPTY_START = 8'h31;
  localparam logic [7:0] K_SEP         = 8'h01;
  localparam logic [7:0] K_END         = 8'h00;
  localparam logic [7:0] K_ALNUM_BIAS  = 8'h55;
  localparam logic [7:0] K_SPACE       = 8'h06;
  localparam logic [7:0] K_PUNCT_HI    = 8'h07;
  localparam logic [7:0] K_PERIOD_HI   = 8'h08;
  localparam logic [7:0] K_COLON_LO    = 8'hD8;
  localparam logic [7:0] K_DASH_LO     = 8'h90;
  localparam logic [7:0] K_COMMA_LO    = 8'hB2;
  localparam logic [7:0] K_PERIOD_LO   = 8'h51;
  localparam logic [7:0] K_APOS_LO     = 8'h31;
  localparam logic [7:0] K_WORD_MARK   = 8'h8F;
  localparam logic [7:0] K_WORD_BASE   = 8'h86;
  localparam logic [7:0] K_FINAL_BASE  = 8'h03;
  localparam logic [7:0] K_COUNT_BIAS  = 8'h04;
  localparam logic [7:0] K_CASE_OFS    = 8'h20;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PERIOD = 8'h2E;
  localparam logic [7:0] CH_APOS   = 8'h27;

endpackage

FILE: hdl/sort_key_encoder.sv
// Sort key encoder: one text byte per request in, one key byte per cycle out while out_ready holds.
// A request is accepted only in the idle state, so a new text byte waits until the key bytes
// of the last one are out; a byte yields 0 to 3 key bytes, empty text yields 4, and a final
// byte adds a trailer of 6 + 2*words key bytes; the word table
// read for each stored word overlaps its word mark byte.
// Reset clears the state, counters, started and overflow flags and output valid; the word table is not cleared.
module sort_key_encoder #(
  parameter int MAX_WORDS = 16,
  parameter int MAX_CHARS = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_last_char,
  input  logic       in_empty_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_key_byte,
  output logic       out_last_key,
  output logic       out_overflow
);
  import ske_pkg::*;

  localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW  = $clog2(MAX_WORDS + 1);
  localparam int CCW = $clog2(MAX_CHARS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_HI    = 4'd2;
  localparam logic [3:0] S_LO    = 4'd3;
  localparam logic [3:0] S_T1    = 4'd4;
  localparam logic [3:0] S_T2    = 4'd5;
  localparam logic [3:0] S_T3    = 4'd6;
  localparam logic [3:0] S_WHI   = 4'd7;
  localparam logic [3:0] S_WLO   = 4'd8;
  localparam logic [3:0] S_FHI   = 4'd9;
  localparam logic [3:0] S_FLO   = 4'd10;
  localparam logic [3:0] S_END   = 4'd11;
  localparam logic [3:0] S_E0    = 4'd12;
  localparam logic [3:0] S_E1    = 4'd13;
  localparam logic [3:0] S_E2    = 4'd14;

  logic [7:0]     word_mem [MAX_WORDS];
  logic [7:0]     rd_data_r;

  logic [3:0]     state_r, state_nxt;
  logic           started_r, started_nxt;
  logic [CCW-1:0] char_cnt_r, char_cnt_nxt;
  logic [CW-1:0]  word_cnt_r, word_cnt_nxt;
  logic [7:0]     word_len_r, word_len_nxt;
  logic           ovf_r, ovf_nxt;
  logic [CW-1:0]  widx_r, widx_nxt;
  logic           enc_r, enc_nxt;
  logic           two_r, two_nxt;
  logic           last_r, last_nxt;
  logic [7:0]     hi_r, hi_nxt;
  logic [7:0]     lo_r, lo_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           accept, emit, wr_en;
  logic [7:0]     c_up, code_hi, code_lo;
  logic           lim, is_alnum, is_space, code_two;
  logic [3:0]     after_code;
  logic [7:0]     emit_byte;

  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign emit         = (state_r != S_IDLE) && (!out_valid_r || out_ready);
  assign after_code   = last_r ? S_T1 : S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_key_byte = out_byte_r;
  assign out_last_key = out_last_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    c_up     = (in_char_byte inside {[8'h61:8'h7A]}) ? in_char_byte - K_CASE_OFS
                                                     : in_char_byte;
    is_alnum = c_up inside {[8'h41:8'h5A], [8'h30:8'h39]};
    is_space = (c_up == CH_SPACE);
    lim      = (char_cnt_r >= CCW'(MAX_CHARS));
    code_hi  = K_PUNCT_HI;
    code_lo  = K_DASH_LO;
    code_two = 1'b1;
    if (is_alnum) begin
      code_hi  = {c_up[6:0], 1'b0} - K_ALNUM_BIAS;
      code_two = 1'b0;
    end else if (is_space) begin
      code_hi  = K_SPACE;
      code_two = 1'b0;
    end else begin
      case (c_up)
        CH_COLON:  code_lo = K_COLON_LO;
        CH_COMMA:  code_lo = K_COMMA_LO;
        CH_PERIOD: begin
          code_hi = K_PERIOD_HI;
          code_lo = K_PERIOD_LO;
        end
        CH_APOS:   code_lo = K_APOS_LO;
        default:   code_lo = K_DASH_LO;
      endcase
    end
  end

  always_comb begin
    case (state_r)
      S_START: emit_byte = K_KEY_START;
      S_HI:    emit_byte = hi_r;
      S_LO:    emit_byte = lo_r;
      S_T1:    emit_byte = K_SEP;
      S_T2:    emit_byte = 8'(char_cnt_r) + K_COUNT_BIAS;
      S_T3:    emit_byte = K_SEP;
      S_WHI:   emit_byte = K_WORD_MARK;
      S_WLO:   emit_byte = K_WORD_BASE - rd_data_r;
      S_FHI:   emit_byte = K_WORD_MARK;
      S_FLO:   emit_byte = K_FINAL_BASE + word_len_r;
      S_E0:    emit_byte = K_EMPTY_START;
      S_E1:    emit_byte = K_SEP;
      S_E2:    emit_byte = K_SEP;
      default: emit_byte = K_END;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    started_nxt  = started_r;
    char_cnt_nxt = char_cnt_r;
    word_cnt_nxt = word_cnt_r;
    word_len_nxt = word_len_r;
    ovf_nxt      = ovf_r;
    widx_nxt     = widx_r;
    enc_nxt      = enc_r;
    two_nxt      = two_r;
    last_nxt     = last_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    wr_en        = 1'b0;

    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (accept) begin
      if (in_empty_text) begin
        started_nxt  = 1'b0;
        char_cnt_nxt = '0;
        word_cnt_nxt = '0;
        word_len_nxt = '0;
        ovf_nxt      = 1'b0;
        state_nxt    = S_E0;
      end else begin
        started_nxt = 1'b1;
        enc_nxt     = !lim;
        two_nxt     = code_two;
        last_nxt    = in_last_char;
        hi_nxt      = code_hi;
        lo_nxt      = code_lo;
        widx_nxt    = '0;
        ovf_nxt     = ovf_r || lim;
        if (!lim) begin
          char_cnt_nxt = char_cnt_r + CCW'(1);
          if (is_space) begin
            word_len_nxt = '0;
            if (word_cnt_r < CW'(MAX_WORDS - 1)) begin
              wr_en        = 1'b1;
              word_cnt_nxt = word_cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            word_len_nxt = word_len_r + 8'd1;
          end
        end
        if (!started_r) begin
          state_nxt = S_START;
        end else if (!lim) begin
          state_nxt = S_HI;
        end else begin
          state_nxt = in_last_char ? S_T1 : S_IDLE;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = (state_r == S_END);
      out_ovf_nxt   = ovf_r && (state_r != S_START);
      case (state_r)
        S_START: state_nxt = enc_r ? S_HI : after_code;
        S_HI:    state_nxt = two_r ? S_LO : after_code;
        S_LO:    state_nxt = after_code;
        S_T1:    state_nxt = S_T2;
        S_T2:    state_nxt = S_T3;
        S_T3:    state_nxt = (word_cnt_r != '0) ? S_WHI : S_FHI;
        S_WHI:   state_nxt = S_WLO;
        S_WLO: begin
          widx_nxt  = widx_r + CW'(1);
          state_nxt = (widx_r + CW'(1) == word_cnt_r) ? S_FHI : S_WHI;
        end
        S_FHI:   state_nxt = S_FLO;
        S_FLO:   state_nxt = S_END;
        S_E0:    state_nxt = S_E1;
        S_E1:    state_nxt = S_E2;
        S_E2:    state_nxt = S_END;
        S_END: begin
          state_nxt    = S_IDLE;
          started_nxt  = 1'b0;
          char_cnt_nxt = '0;
          word_cnt_nxt = '0;
          word_len_nxt = '0;
          ovf_nxt      = 1'b0;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_mem[word_cnt_r[AW-1:0]] <= word_len_r;
    end
    rd_data_r <= word_mem[widx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      char_cnt_r  <= '0;
      word_cnt_r  <= '0;
      word_len_r  <= '0;
      ovf_r       <= 1'b0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      char_cnt_r  <= char_cnt_nxt;
      word_cnt_r  <= word_cnt_nxt;
      word_len_r  <= word_len_nxt;
      ovf_r       <= ovf_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    enc_r      <= enc_nxt;
    two_r      <= two_nxt;
    last_r     <= last_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  a_word_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_cnt_r <= CW'(MAX_WORDS - 1))
    else $error("stored word count beyond table limit");

  a_char_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_cnt_r <= CCW'(MAX_CHARS))
    else $error("character count beyond limit");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WLO) |-> (widx_r < word_cnt_r))
    else $error("word table walk past stored words");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (state_r == S_END)) |=> (state_r == S_IDLE && char_cnt_r == '0
                                      && !ovf_r && out_last_key))
    else $error("final key byte did not close the string");

endmodule

FILE: tb/testbench.sv
// Testbench for the sort key encoder: predicted key bytes checked against the block output.
`timescale 1ns / 1ps

module testbench;
  import ske_pkg::*;

  localparam int MAX_WORDS = 16;
  localparam int MAX_CHARS = 128;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_key;
    logic       overflow;
  } key_byte_t;

  class key_scoreboard;
    key_byte_t  pending_keys[$];
    int         errors;
    bit         started;
    int         char_count;
    int         word_count;
    logic [7:0] word_length;
    logic [7:0] word_table[MAX_WORDS];
    bit         overflow_seen;

    function new();
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      started       = 1'b0;
      char_count    = 0;
      word_count    = 0;
      word_length   = 8'h00;
      overflow_seen = 1'b0;
    endfunction

    function void push_key(logic [7:0] b, bit last);
      key_byte_t k;
      k.key_byte = b;
      k.last_key = last;
      k.overflow = overflow_seen;
      pending_keys = {pending_keys, k};
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction

    function void note_request(logic [7:0] char_in, bit last, bit empty);
      logic [7:0] c;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] code;
      c = char_in;
      if (empty) begin
        clear_string();
        push_key(K_EMPTY_START, 1'b0);
        push_key(K_SEP, 1'b0);
        push_key(K_SEP, 1'b0);
        push_key(K_END, 1'b1);
        return;
      end
      if (c >= 8'h61 && c <= 8'h7A) c = c - K_CASE_OFS;
      if (char_count >= MAX_CHARS) overflow_seen = 1'b1;
      if (!started) begin
        started = 1'b1;
        push_key(K_KEY_START, 1'b0);
      end
      if (char_count < MAX_CHARS) begin
        char_count++;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39)) begin
          word_length = word_length + 8'h01;
          code = {c[6:0], 1'b0} - K_ALNUM_BIAS;
          push_key(code, 1'b0);
        end else if (c == CH_SPACE) begin
          if (word_count < MAX_WORDS - 1) begin
            word_table[word_count] = word_length;
            word_count++;
          end else begin
            overflow_seen = 1'b1;
          end
          word_length = 8'h00;
          push_key(K_SPACE, 1'b0);
        end else begin
          hi = K_PUNCT_HI;
          lo = K_DASH_LO;
          case (c)
            CH_COLON: lo = K_COLON_LO;
            CH_COMMA: lo = K_COMMA_LO;
            CH_PERIOD: begin
              hi = K_PERIOD_HI;
              lo = K_PERIOD_LO;
            end
            CH_APOS: lo = K_APOS_LO;
            default: ;
          endcase
          word_length = word_length + 8'h01;
          push_key(hi, 1'b0);
          push_key(lo, 1'b0);
        end
      end
      if (last) begin
        push_key(K_SEP, 1'b0);
        code = 8'(char_count) + K_COUNT_BIAS;
        push_key(code, 1'b0);
        push_key(K_SEP, 1'b0);
        for (int i = 0; i < word_count; i++) begin
          push_key(K_WORD_MARK, 1'b0);
          code = K_WORD_BASE - word_table[i];
          push_key(code, 1'b0);
        end
        push_key(K_WORD_MARK, 1'b0);
        code = K_FINAL_BASE + word_length;
        push_key(code, 1'b0);
        push_key(K_END, 1'b1);
        clear_string();
      end
    endfunction

    task report(string msg);
      if (errors < 30) $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_key_byte(logic [7:0] b, logic last, logic ovf);
      key_byte_t k;
      if (pending_keys.size() == 0) begin
        report($sformatf("unexpected key byte %02h", b));
        return;
      end
      k = pending_keys.pop_front();
      if (b !== k.key_byte)
        report($sformatf("key_byte %02h, want %02h", b, k.key_byte));
      if (last !== k.last_key)
        report($sformatf("last_key %b, want %b (byte %02h)", last, k.last_key, k.key_byte));
      if (ovf !== k.overflow)
        report($sformatf("overflow %b, want %b (byte %02h)", ovf, k.overflow, k.key_byte));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char_byte = 8'h00;
  logic       in_last_char = 1'b0;
  logic       in_empty_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_key_byte;
  logic       out_last_key;
  logic       out_overflow;

  key_scoreboard sb = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int requests_sent = 0;

  sort_key_encoder #(
    .MAX_WORDS(MAX_WORDS),
    .MAX_CHARS(MAX_CHARS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char_byte(in_char_byte),
    .in_last_char(in_last_char),
    .in_empty_text(in_empty_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key_byte(out_key_byte),
    .out_last_key(out_last_key),
    .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_key_byte(out_key_byte, out_last_key, out_overflow);
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task send_request(logic [7:0] c, bit last, bit empty);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_byte  <= c;
    in_last_char  <= last;
    in_empty_text <= empty;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, last, empty);
    requests_sent++;
  endtask

  function logic [7:0] pick_char();
    case ($urandom_range(9))
      0, 1, 2: return 8'(8'h61 + $urandom_range(25));
      3:       return 8'(8'h41 + $urandom_range(25));
      4:       return 8'(8'h30 + $urandom_range(9));
      5, 6:    return CH_SPACE;
      7: begin
        case ($urandom_range(4))
          0:       return CH_COLON;
          1:       return CH_COMMA;
          2:       return CH_PERIOD;
          3:       return CH_APOS;
          default: return 8'h2D;
        endcase
      end
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task send_string(int len);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(29) == 0)
        send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      send_request(pick_char(), i == len - 1, 1'b0);
    end
  endtask

  task run_phase(int idle_pct, int stall_pct, int count);
    int target;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    target = requests_sent + count;
    while (requests_sent < target) begin
      if ($urandom_range(9) == 0)
        send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      else if ($urandom_range(9) == 0)
        send_string($urandom_range(30, 12));
      else
        send_string($urandom_range(8, 1));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h41, 1'b0, 1'b0);
    send_request(8'h7A, 1'b0, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'h30, 1'b0, 1'b0);
    send_request(8'h39, 1'b0, 1'b0);
    send_request(CH_SPACE, 1'b0, 1'b0);
    send_request(CH_COLON, 1'b0, 1'b0);
    send_request(8'h2D, 1'b0, 1'b0);
    send_request(CH_COMMA, 1'b0, 1'b0);
    send_request(CH_PERIOD, 1'b0, 1'b0);
    send_request(CH_APOS, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h7B, 1'b0, 1'b0);
    send_request(8'h60, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h71, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'h78, 1'b0, 1'b0);
    send_request(CH_SPACE, 1'b1, 1'b0);
    send_request(CH_SPACE, 1'b1, 1'b0);

    run_phase(0, 0, 6);
    run_phase(67, 0, 6);
    run_phase(0, 67, 6);
    sender_idle_pct    = 18;
    receiver_stall_pct = 18;
    for (int i = 0; i < MAX_CHARS + 2; i++)
      send_request((i % 4 == 3) ? CH_SPACE : pick_char(), i == MAX_CHARS + 1, 1'b0);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
